>>> hw/rtl/c8pd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package c8pd_pkg;

   localparam int unsigned COUNT_W = 5;

   // Byte positions within a packet
   localparam logic [COUNT_W-1:0] POS_MAGIC     = 5'd0;
   localparam logic [COUNT_W-1:0] POS_TYPE      = 5'd1;
   localparam logic [COUNT_W-1:0] POS_SENDER    = 5'd2;
   localparam logic [COUNT_W-1:0] POS_TARGET    = 5'd3;
   localparam logic [COUNT_W-1:0] POS_ORIGIN    = 5'd4;
   localparam logic [COUNT_W-1:0] POS_EPOCH     = 5'd5;
   localparam logic [COUNT_W-1:0] POS_SEQUENCE  = 5'd9;
   localparam logic [COUNT_W-1:0] POS_LONGITUDE = 5'd11;
   localparam logic [COUNT_W-1:0] POS_LATITUDE  = 5'd13;
   localparam logic [COUNT_W-1:0] POS_SCORE     = 5'd15;
   localparam logic [COUNT_W-1:0] POS_RESERVED  = 5'd16;
   localparam logic [COUNT_W-1:0] POS_CHECK     = 5'd17;
   localparam logic [COUNT_W-1:0] PACKET_BYTES  = 5'd18;
   localparam logic [COUNT_W-1:0] COUNT_MAX     = 5'd31;

   localparam logic [7:0] MAGIC_BYTE = 8'hA2;
   localparam logic [7:0] CRC_POLY   = 8'h07;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_LENGTH   = 3'd1,
      ST_MAGIC    = 3'd2,
      ST_TYPE     = 3'd3,
      ST_SCORE    = 3'd4,
      ST_RESERVED = 3'd5,
      ST_CHECKSUM = 3'd6,
      ST_ROUTING  = 3'd7
   } status_type;

   typedef struct packed {
      logic [7:0] min_type;
      logic [7:0] max_type;
      logic [7:0] node_count;
      logic [7:0] broadcast_id;
      logic [7:0] max_score;
   } cfg_type;

   typedef struct packed {
      status_type         status;
      logic [7:0]         msg_type;
      logic [7:0]         sender;
      logic [7:0]         target;
      logic [7:0]         key_origin;
      logic [31:0]        key_epoch;
      logic [15:0]        sequence_res;
      logic signed [15:0] longitude_centideg;
      logic signed [15:0] latitude_centideg;
      logic [7:0]         score;
   } result_type;

   // CRC-8, polynomial 0x07, MSB first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/c8pd_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface c8pd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, output data_byte, output last_byte, input ready);
   modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface c8pd_rsp_if;
   import c8pd_pkg::*;
   logic               valid;
   logic               ready;
   status_type         status;
   logic [7:0]         msg_type;
   logic [7:0]         sender;
   logic [7:0]         target;
   logic [7:0]         key_origin;
   logic [31:0]        key_epoch;
   logic [15:0]        sequence_res;
   logic signed [15:0] longitude_centideg;
   logic signed [15:0] latitude_centideg;
   logic [7:0]         score;

   modport source (
      output valid, output status, output msg_type, output sender, output target,
      output key_origin, output key_epoch, output sequence_res,
      output longitude_centideg, output latitude_centideg, output score,
      input ready
   );
   modport sink (
      input valid, input status, input msg_type, input sender, input target,
      input key_origin, input key_epoch, input sequence_res,
      input longitude_centideg, input latitude_centideg, input score,
      output ready
   );
endinterface

`default_nettype wire

>>> hw/rtl/c8pd_csr.sv
`timescale 1ns / 1ps
`default_nettype none

module c8pd_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           psel,
   input  wire logic           penable,
   input  wire logic           pwrite,
   input  wire logic [4:0]     paddr,
   input  wire logic [31:0]    pwdata,
   output logic [31:0]         prdata,
   output logic                pready,
   output c8pd_pkg::cfg_type   cfg
);
   import c8pd_pkg::*;

   localparam logic [2:0] REG_MIN_TYPE     = 3'd0;
   localparam logic [2:0] REG_MAX_TYPE     = 3'd1;
   localparam logic [2:0] REG_NODE_COUNT   = 3'd2;
   localparam logic [2:0] REG_BROADCAST_ID = 3'd3;
   localparam logic [2:0] REG_MAX_SCORE    = 3'd4;

   cfg_type    cfg_ff, cfg_in;
   logic [2:0] reg_index;
   logic       write_en;

   assign reg_index = paddr[4:2];
   assign write_en  = psel && penable && pwrite;
   assign pready    = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (write_en) begin
         case (reg_index)
            REG_MIN_TYPE:     cfg_in.min_type     = pwdata[7:0];
            REG_MAX_TYPE:     cfg_in.max_type     = pwdata[7:0];
            REG_NODE_COUNT:   cfg_in.node_count   = pwdata[7:0];
            REG_BROADCAST_ID: cfg_in.broadcast_id = pwdata[7:0];
            REG_MAX_SCORE:    cfg_in.max_score    = pwdata[7:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_MIN_TYPE:     prdata = {24'd0, cfg_ff.min_type};
         REG_MAX_TYPE:     prdata = {24'd0, cfg_ff.max_type};
         REG_NODE_COUNT:   prdata = {24'd0, cfg_ff.node_count};
         REG_BROADCAST_ID: prdata = {24'd0, cfg_ff.broadcast_id};
         REG_MAX_SCORE:    prdata = {24'd0, cfg_ff.max_score};
         default:          prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_type     <= 8'd1;
         cfg_ff.max_type     <= 8'd4;
         cfg_ff.node_count   <= 8'd16;
         cfg_ff.broadcast_id <= 8'd255;
         cfg_ff.max_score    <= 8'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/c8pd_frame.sv
`timescale 1ns / 1ps
`default_nettype none

module c8pd_frame (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             step,
   input  wire logic [7:0]       data_byte,
   input  wire logic             last_byte,
   input  wire c8pd_pkg::cfg_type cfg,
   output c8pd_pkg::result_type  result
);
   import c8pd_pkg::*;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         crc_ff, crc_in;
   logic               magic_ff, magic_in;
   logic [7:0]         type_ff, type_in;
   logic [7:0]         sender_ff, sender_in;
   logic [7:0]         target_ff, target_in;
   logic [7:0]         origin_ff, origin_in;
   logic [31:0]        epoch_ff, epoch_in;
   logic [15:0]        sequence_ff, sequence_in;
   logic [15:0]        longitude_ff, longitude_in;
   logic [15:0]        latitude_ff, latitude_in;
   logic [7:0]         score_ff, score_in;
   logic [7:0]         reserved_ff, reserved_in;
   logic [7:0]         check_ff, check_in;
   logic [COUNT_W-1:0] idx;
   logic               routing_ok;

   assign idx = count_ff;

   // Capture the current byte into the running packet state
   always_comb begin
      count_in     = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;
      crc_in       = (idx < POS_CHECK) ? crc8_byte(crc_ff, data_byte) : crc_ff;
      magic_in     = magic_ff;
      type_in      = type_ff;
      sender_in    = sender_ff;
      target_in    = target_ff;
      origin_in    = origin_ff;
      epoch_in     = epoch_ff;
      sequence_in  = sequence_ff;
      longitude_in = longitude_ff;
      latitude_in  = latitude_ff;
      score_in     = score_ff;
      reserved_in  = reserved_ff;
      check_in     = check_ff;
      if (idx == POS_MAGIC)    magic_in    = (data_byte == MAGIC_BYTE);
      if (idx == POS_TYPE)     type_in     = data_byte;
      if (idx == POS_SENDER)   sender_in   = data_byte;
      if (idx == POS_TARGET)   target_in   = data_byte;
      if (idx == POS_ORIGIN)   origin_in   = data_byte;
      if (idx >= POS_EPOCH && idx < POS_SEQUENCE) begin
         epoch_in = {epoch_ff[23:0], data_byte};
      end
      if (idx >= POS_SEQUENCE && idx < POS_LONGITUDE) begin
         sequence_in = {sequence_ff[7:0], data_byte};
      end
      if (idx >= POS_LONGITUDE && idx < POS_LATITUDE) begin
         longitude_in = {longitude_ff[7:0], data_byte};
      end
      if (idx >= POS_LATITUDE && idx < POS_SCORE) begin
         latitude_in = {latitude_ff[7:0], data_byte};
      end
      if (idx == POS_SCORE)    score_in    = data_byte;
      if (idx == POS_RESERVED) reserved_in = data_byte;
      if (idx == POS_CHECK)    check_in    = data_byte;
   end

   assign routing_ok = (sender_in < cfg.node_count) &&
                       ((target_in < cfg.node_count) || (target_in == cfg.broadcast_id));

   // First failing check wins
   always_comb begin
      if (count_in != PACKET_BYTES) begin
         result.status = ST_LENGTH;
      end else if (!magic_in) begin
         result.status = ST_MAGIC;
      end else if (type_in < cfg.min_type || type_in > cfg.max_type) begin
         result.status = ST_TYPE;
      end else if (score_in > cfg.max_score) begin
         result.status = ST_SCORE;
      end else if (reserved_in != 8'd0) begin
         result.status = ST_RESERVED;
      end else if (check_in != crc_in) begin
         result.status = ST_CHECKSUM;
      end else if (!routing_ok) begin
         result.status = ST_ROUTING;
      end else begin
         result.status = ST_OK;
      end
      result.msg_type           = type_in;
      result.sender             = sender_in;
      result.target             = target_in;
      result.key_origin         = origin_in;
      result.key_epoch          = epoch_in;
      result.sequence_res       = sequence_in;
      result.longitude_centideg = longitude_in;
      result.latitude_centideg  = latitude_in;
      result.score              = score_in;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         count_ff     <= '0;
         crc_ff       <= '0;
         magic_ff     <= 1'b0;
         type_ff      <= '0;
         sender_ff    <= '0;
         target_ff    <= '0;
         origin_ff    <= '0;
         epoch_ff     <= '0;
         sequence_ff  <= '0;
         longitude_ff <= '0;
         latitude_ff  <= '0;
         score_ff     <= '0;
         reserved_ff  <= '0;
         check_ff     <= '0;
      end else if (step) begin
         count_ff     <= count_in;
         crc_ff       <= crc_in;
         magic_ff     <= magic_in;
         type_ff      <= type_in;
         sender_ff    <= sender_in;
         target_ff    <= target_in;
         origin_ff    <= origin_in;
         epoch_ff     <= epoch_in;
         sequence_ff  <= sequence_in;
         longitude_ff <= longitude_in;
         latitude_ff  <= latitude_in;
         score_ff     <= score_in;
         reserved_ff  <= reserved_in;
         check_ff     <= check_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/crc8_packet_deframer.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Role         Handshake          Payload
// req_bus   byte in      valid/ready        data_byte, last_byte
// rsp_bus   result out   valid/ready        status and decoded packet fields
// csr       registers    APB, pready high   min_type .. max_score at 4*i
//
// One word per clock sustained. A word is held in an input register, then the
// packet state and the CRC-8 update from it; the last word loads the result
// register, and rsp valid rises as that register is loaded.
// Reset clears the packet state and loads register defaults. A result waiting in
// the result register stalls a following last word and the words behind it.

module crc8_packet_deframer (
   input  wire logic        clock,
   input  wire logic        reset,
   c8pd_req_if.sink         req_bus,
   c8pd_rsp_if.source       rsp_bus,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [4:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import c8pd_pkg::*;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type frame_result;
   cfg_type    cfg;
   logic       advance;
   logic       take_req;

   c8pd_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   c8pd_frame u_frame (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .data_byte (in_byte_ff),
      .last_byte (in_last_ff),
      .cfg       (cfg),
      .result    (frame_result)
   );

   // A last word may move on only when the result register can take it
   assign advance       = in_valid_ff && (!in_last_ff || !rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign take_req      = req_bus.valid && req_bus.ready;
   assign in_valid_in   = take_req || (in_valid_ff && !advance);
   assign rsp_valid_in  = (advance && in_last_ff) || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_req) begin
         in_byte_ff <= req_bus.data_byte;
         in_last_ff <= req_bus.last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_data_ff <= frame_result;
      end
   end

   assign rsp_bus.valid              = rsp_valid_ff;
   assign rsp_bus.status             = rsp_data_ff.status;
   assign rsp_bus.msg_type           = rsp_data_ff.msg_type;
   assign rsp_bus.sender             = rsp_data_ff.sender;
   assign rsp_bus.target             = rsp_data_ff.target;
   assign rsp_bus.key_origin         = rsp_data_ff.key_origin;
   assign rsp_bus.key_epoch          = rsp_data_ff.key_epoch;
   assign rsp_bus.sequence_res       = rsp_data_ff.sequence_res;
   assign rsp_bus.longitude_centideg = rsp_data_ff.longitude_centideg;
   assign rsp_bus.latitude_centideg  = rsp_data_ff.latitude_centideg;
   assign rsp_bus.score              = rsp_data_ff.score;

endmodule

`default_nettype wire
